// ===== hdl/font3x5_text_pixel_generator_defines.svh =====
// shared assertion macros for the font pixel generator
`ifndef FONT3X5_TEXT_PIXEL_GENERATOR_DEFINES_SVH
`define FONT3X5_TEXT_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define FNT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnt assertion failed");

// next-cycle implication, checked on clk outside reset
`define FNT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fnt assertion failed");

`endif

// ===== hdl/fnt_pkg.sv =====
package fnt_pkg;

  localparam int GLYPH_COUNT = 36;
  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_COLS  = 3;
  localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int DIGIT_BASE  = 26;
  localparam int COORD_W     = 7;
  localparam int COLOUR_W    = 24;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] STEP_SPACE = 8'd2;
  localparam logic [7:0] STEP_GLYPH = 8'd4;

  typedef logic [GLYPH_BITS-1:0] pix_mask_t;
  typedef logic [5:0]            glyph_idx_t;

  // one character ready to be drawn: bit r*3+c of mask is row r, column c
  typedef struct packed {
    pix_mask_t             mask;
    logic [COORD_W-1:0]    col_base;
    logic [COORD_W-1:0]    row_base;
    logic [COLOUR_W-1:0]   colour;
  } job_t;

  // glyph rows top first, each 3-bit line with the leftmost column in bit 2
  function automatic logic [GLYPH_BITS-1:0] glyph_pack(input logic [2:0] l0,
                                                        input logic [2:0] l1,
                                                        input logic [2:0] l2,
                                                        input logic [2:0] l3,
                                                        input logic [2:0] l4);
    return {l4, l3, l2, l1, l0};
  endfunction

  localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
    glyph_pack(3'd2, 3'd5, 3'd7, 3'd5, 3'd5), glyph_pack(3'd6, 3'd5, 3'd6, 3'd5, 3'd6),
    glyph_pack(3'd3, 3'd4, 3'd4, 3'd4, 3'd3), glyph_pack(3'd6, 3'd5, 3'd5, 3'd5, 3'd6),
    glyph_pack(3'd7, 3'd4, 3'd6, 3'd4, 3'd7), glyph_pack(3'd7, 3'd4, 3'd6, 3'd4, 3'd4),
    glyph_pack(3'd3, 3'd4, 3'd5, 3'd5, 3'd3), glyph_pack(3'd5, 3'd5, 3'd7, 3'd5, 3'd5),
    glyph_pack(3'd7, 3'd2, 3'd2, 3'd2, 3'd7), glyph_pack(3'd1, 3'd1, 3'd1, 3'd5, 3'd3),
    glyph_pack(3'd5, 3'd6, 3'd4, 3'd6, 3'd5), glyph_pack(3'd4, 3'd4, 3'd4, 3'd4, 3'd7),
    glyph_pack(3'd5, 3'd7, 3'd7, 3'd5, 3'd5), glyph_pack(3'd6, 3'd5, 3'd5, 3'd5, 3'd5),
    glyph_pack(3'd2, 3'd5, 3'd5, 3'd5, 3'd2), glyph_pack(3'd6, 3'd5, 3'd6, 3'd4, 3'd4),
    glyph_pack(3'd2, 3'd5, 3'd5, 3'd6, 3'd3), glyph_pack(3'd6, 3'd5, 3'd6, 3'd5, 3'd5),
    glyph_pack(3'd3, 3'd4, 3'd2, 3'd1, 3'd6), glyph_pack(3'd7, 3'd2, 3'd2, 3'd2, 3'd2),
    glyph_pack(3'd5, 3'd5, 3'd5, 3'd5, 3'd7), glyph_pack(3'd5, 3'd5, 3'd5, 3'd5, 3'd2),
    glyph_pack(3'd5, 3'd5, 3'd5, 3'd7, 3'd5), glyph_pack(3'd5, 3'd5, 3'd2, 3'd5, 3'd5),
    glyph_pack(3'd5, 3'd5, 3'd2, 3'd2, 3'd2), glyph_pack(3'd7, 3'd1, 3'd2, 3'd4, 3'd7),
    glyph_pack(3'd7, 3'd5, 3'd5, 3'd5, 3'd7), glyph_pack(3'd2, 3'd6, 3'd2, 3'd2, 3'd7),
    glyph_pack(3'd7, 3'd1, 3'd7, 3'd4, 3'd7), glyph_pack(3'd7, 3'd1, 3'd7, 3'd1, 3'd7),
    glyph_pack(3'd5, 3'd5, 3'd7, 3'd1, 3'd1), glyph_pack(3'd7, 3'd4, 3'd7, 3'd1, 3'd7),
    glyph_pack(3'd7, 3'd4, 3'd7, 3'd5, 3'd7), glyph_pack(3'd7, 3'd1, 3'd2, 3'd4, 3'd4),
    glyph_pack(3'd7, 3'd5, 3'd7, 3'd5, 3'd7), glyph_pack(3'd7, 3'd5, 3'd7, 3'd1, 3'd7)
  };

endpackage

// ===== hdl/font3x5_text_pixel_generator.sv =====
// 3x5 font pixel generator
// in_*  : one character per request. in_tuser is the first-of-string flag, which
//         loads the cursor column from start_column before the glyph is drawn.
// out_* : one lit, on-matrix pixel per request, row-major from the glyph's top
//         left. out_tlast marks the last pixel of a character. Characters with
//         no visible pixel (space, unsupported codes, fully clipped glyphs)
//         give no output but still move the cursor (space by 2, others by 4).
// cfg_* : writes invert_text; 1 mirrors both axes. Write only while idle.
// The first pixel of a character goes from the decode register (loaded on the
// accepting edge) to the walker and then to the output register.
// Throughput: one pixel per cycle from the walker while out_tready does not
// stall it; a character holds the walker until all of its visible pixels (1 to
// 15) have gone. Characters with nothing to draw never reach the walker. A decode
// register in front lets the next character be taken while pixels still go out.
// A stalled out_tready holds the output register and, behind it, the walker
// and the decode register, which then drops in_tready.
// Reset (rst_n low, synchronous) clears the cursor, invert_text and all valids.
module font3x5_text_pixel_generator #(
  parameter int MATRIX_COLUMNS = 32,
  parameter int MATRIX_ROWS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], start_column[15:8], top_row[23:16], pixel_colour[47:24]
  input  logic [47:0] in_tdata,
  // first_of_string
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_column[6:0], out_row[13:7], out_colour[37:14], zero fill[39:38]
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic          invert_r;
  logic          job_valid;
  logic          job_ready;
  fnt_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      invert_r <= cfg_data;
    end
  end

  fnt_decode #(
    .MATRIX_COLUMNS (MATRIX_COLUMNS),
    .MATRIX_ROWS    (MATRIX_ROWS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  fnt_emit #(
    .MATRIX_COLUMNS (MATRIX_COLUMNS),
    .MATRIX_ROWS    (MATRIX_ROWS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .invert_text (invert_r),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== hdl/fnt_decode.sv =====
`include "font3x5_text_pixel_generator_defines.svh"

module fnt_decode #(
  parameter int MATRIX_COLUMNS = 32,
  parameter int MATRIX_ROWS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,
  input  logic          in_tuser,
  output logic          job_valid,
  input  logic          job_ready,
  output fnt_pkg::job_t job
);

  logic [7:0]  char_code;
  logic [7:0]  start_column;
  logic [7:0]  top_row;
  logic [23:0] pixel_colour;

  logic [7:0]  cursor_r;
  logic [7:0]  cursor_nxt;
  logic [7:0]  base_col;
  logic        job_valid_r;
  fnt_pkg::job_t job_r;

  logic                       in_fire;
  logic                       glyph_hit;
  fnt_pkg::glyph_idx_t        glyph_idx;
  logic [7:0]                 digit_off;
  logic [7:0]                 letter_off;
  logic [fnt_pkg::GLYPH_BITS-1:0] glyph_rows;
  logic signed [9:0]          col_sum [fnt_pkg::GLYPH_COLS];
  logic signed [9:0]          row_sum [fnt_pkg::GLYPH_ROWS];
  logic [fnt_pkg::GLYPH_COLS-1:0] col_ok;
  logic [fnt_pkg::GLYPH_ROWS-1:0] row_ok;
  fnt_pkg::pix_mask_t         vis_mask;

  assign char_code    = in_tdata[7:0];
  assign start_column = in_tdata[15:8];
  assign top_row      = in_tdata[23:16];
  assign pixel_colour = in_tdata[47:24];

  assign in_tready = !job_valid_r || job_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign job_valid = job_valid_r;
  assign job       = job_r;

  assign base_col   = in_tuser ? start_column : cursor_r;
  assign cursor_nxt = base_col + ((char_code == fnt_pkg::CHAR_SPACE) ?
                                  fnt_pkg::STEP_SPACE : fnt_pkg::STEP_GLYPH);

  assign letter_off = char_code - fnt_pkg::CHAR_A;
  assign digit_off  = char_code - fnt_pkg::CHAR_0;

  always_comb begin
    glyph_hit = 1'b0;
    glyph_idx = '0;
    if (char_code >= fnt_pkg::CHAR_A && char_code <= fnt_pkg::CHAR_Z) begin
      glyph_hit = 1'b1;
      glyph_idx = letter_off[5:0];
    end else if (char_code >= fnt_pkg::CHAR_0 && char_code <= fnt_pkg::CHAR_9) begin
      glyph_hit = 1'b1;
      glyph_idx = 6'(fnt_pkg::DIGIT_BASE) + digit_off[5:0];
    end
  end

  assign glyph_rows = fnt_pkg::FONT_ROM[glyph_idx];

  // clip window test on the unmirrored coordinates
  always_comb begin
    for (int c = 0; c < fnt_pkg::GLYPH_COLS; c++) begin
      col_sum[c] = $signed({{2{base_col[7]}}, base_col}) + 10'(c);
      col_ok[c]  = (col_sum[c] >= 10'sd1) &&
                   (col_sum[c] <= $signed(10'(MATRIX_COLUMNS)));
    end
    for (int r = 0; r < fnt_pkg::GLYPH_ROWS; r++) begin
      row_sum[r] = $signed({{2{top_row[7]}}, top_row}) + 10'(r);
      row_ok[r]  = (row_sum[r] >= 10'sd1) &&
                   (row_sum[r] <= $signed(10'(MATRIX_ROWS)));
    end
    for (int r = 0; r < fnt_pkg::GLYPH_ROWS; r++) begin
      for (int c = 0; c < fnt_pkg::GLYPH_COLS; c++) begin
        vis_mask[r*fnt_pkg::GLYPH_COLS + c] =
          glyph_hit && row_ok[r] && col_ok[c] &&
          glyph_rows[r*fnt_pkg::GLYPH_COLS + (fnt_pkg::GLYPH_COLS - 1 - c)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      job_valid_r <= 1'b0;
    end else if (in_fire) begin
      cursor_r    <= cursor_nxt;
      // characters with nothing visible leave no request behind
      job_valid_r <= (vis_mask != '0);
    end else if (job_ready) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_r.mask     <= vis_mask;
      job_r.col_base <= base_col[fnt_pkg::COORD_W-1:0];
      job_r.row_base <= top_row[fnt_pkg::COORD_W-1:0];
      job_r.colour   <= pixel_colour;
    end
  end

  `FNT_ASSERT_IMPLIES(a_job_has_pixels, job_valid_r, job_r.mask != '0)
  `FNT_ASSERT_NEXT(a_space_step,
    in_fire && !in_tuser && char_code == fnt_pkg::CHAR_SPACE,
    cursor_r == $past(cursor_r) + fnt_pkg::STEP_SPACE)
  `FNT_ASSERT_NEXT(a_cursor_hold, !in_fire, cursor_r == $past(cursor_r))

endmodule

// ===== hdl/fnt_emit.sv =====
`include "font3x5_text_pixel_generator_defines.svh"

module fnt_emit #(
  parameter int MATRIX_COLUMNS = 32,
  parameter int MATRIX_ROWS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          invert_text,
  input  logic          job_valid,
  output logic          job_ready,
  input  fnt_pkg::job_t job,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata,
  output logic          out_tlast
);

  fnt_pkg::pix_mask_t                mask_r;
  fnt_pkg::pix_mask_t                rest;
  logic [fnt_pkg::COORD_W-1:0]       col_base_r;
  logic [fnt_pkg::COORD_W-1:0]       row_base_r;
  logic [fnt_pkg::COLOUR_W-1:0]      colour_r;

  logic                              out_valid_r;
  logic                              out_last_r;
  logic [fnt_pkg::COORD_W-1:0]       out_col_r;
  logic [fnt_pkg::COORD_W-1:0]       out_row_r;
  logic [fnt_pkg::COLOUR_W-1:0]      out_colour_r;

  logic                              emit;
  logic                              found;
  logic [2:0]                        sel_row;
  logic [fnt_pkg::GLYPH_COLS-1:0]    sel_line;
  logic [1:0]                        sel_col;
  logic [fnt_pkg::COORD_W-1:0]       px;
  logic [fnt_pkg::COORD_W-1:0]       py;
  logic [fnt_pkg::COORD_W-1:0]       col_nxt;
  logic [fnt_pkg::COORD_W-1:0]       row_nxt;

  assign emit      = (mask_r != '0) && (!out_valid_r || out_tready);
  assign rest      = mask_r & (mask_r - 1'b1);
  assign job_ready = (mask_r == '0) || (emit && rest == '0);

  // lowest set bit in row-major order: first non-empty row, then its left column
  always_comb begin
    found    = 1'b0;
    sel_row  = '0;
    sel_line = '0;
    for (int r = 0; r < fnt_pkg::GLYPH_ROWS; r++) begin
      if (!found && (|mask_r[r*fnt_pkg::GLYPH_COLS +: fnt_pkg::GLYPH_COLS])) begin
        found    = 1'b1;
        sel_row  = 3'(r);
        sel_line = mask_r[r*fnt_pkg::GLYPH_COLS +: fnt_pkg::GLYPH_COLS];
      end
    end
    if (sel_line[0]) begin
      sel_col = 2'd0;
    end else if (sel_line[1]) begin
      sel_col = 2'd1;
    end else begin
      sel_col = 2'd2;
    end
  end

  assign px      = col_base_r + 7'(sel_col);
  assign py      = row_base_r + 7'(sel_row);
  assign col_nxt = invert_text ? (7'(MATRIX_COLUMNS + 1) - px) : px;
  assign row_nxt = invert_text ? (7'(MATRIX_ROWS + 1) - py) : py;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        mask_r <= job.mask;
      end else if (emit) begin
        mask_r <= rest;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      col_base_r <= job.col_base;
      row_base_r <= job.row_base;
      colour_r   <= job.colour;
    end
    if (emit) begin
      out_col_r    <= col_nxt;
      out_row_r    <= row_nxt;
      out_colour_r <= colour_r;
      out_last_r   <= (rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_colour_r, out_row_r, out_col_r};

  `FNT_ASSERT_NEXT(a_emit_loads_output, emit, out_valid_r)
  `FNT_ASSERT_IMPLIES(a_more_pending, out_valid_r && !out_last_r, mask_r != '0)
  `FNT_ASSERT_IMPLIES(a_column_range, out_valid_r,
    out_col_r >= 7'd1 && out_col_r <= 7'(MATRIX_COLUMNS))

endmodule

// ===== tb/sv/tb_font3x5_text_pixel_generator.sv =====
module tb_font3x5_text_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 32;
  localparam int ROWS = 16;

  // one octal digit per glyph row, top row in the highest digit, left column in its msb
  localparam logic [14:0] GLYPH_LINES [36] = '{
    15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74647, 15'o74644,
    15'o34553, 15'o55755, 15'o72227, 15'o11153, 15'o56465, 15'o44447,
    15'o57755, 15'o65555, 15'o25552, 15'o65644, 15'o25563, 15'o65655,
    15'o34216, 15'o72222, 15'o55557, 15'o55552, 15'o55575, 15'o55255,
    15'o55222, 15'o71247,
    15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711, 15'o74717,
    15'o74757, 15'o71244, 15'o75757, 15'o75717
  };

  typedef struct {
    logic [7:0]        code;
    logic              first;
    logic signed [7:0] start_col;
    logic signed [7:0] top_row;
    logic [23:0]       colour;
  } char_req_t;

  typedef struct {
    logic [6:0]  col;
    logic [6:0]  row;
    logic [23:0] colour;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  char_req_t         chars_to_send[$];
  char_req_t         char_on_bus;
  pixel_t            pixels_due[$];
  logic signed [7:0] cursor_col = '0;
  logic              mirror_on = 1'b0;
  logic              no_gaps = 1'b0;
  logic              failed = 1'b0;

  font3x5_text_pixel_generator #(
    .MATRIX_COLUMNS(COLS),
    .MATRIX_ROWS   (ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 33);
  endfunction

  // works out the pixels of one accepted character and moves the cursor
  task automatic draw_char(input char_req_t req);
    int         glyph;
    int         x;
    int         top;
    int         px;
    int         py;
    logic [2:0] line;
    pixel_t     pix;
    pixel_t     drawn[$];
    if (req.first) cursor_col = req.start_col;
    x = cursor_col;
    top = req.top_row;
    glyph = -1;
    if (req.code >= fnt_pkg::CHAR_A && req.code <= fnt_pkg::CHAR_Z) begin
      glyph = req.code - fnt_pkg::CHAR_A;
    end else if (req.code >= fnt_pkg::CHAR_0 && req.code <= fnt_pkg::CHAR_9) begin
      glyph = fnt_pkg::DIGIT_BASE + (req.code - fnt_pkg::CHAR_0);
    end
    if (glyph >= 0) begin
      for (int r = 0; r < 5; r++) begin
        line = GLYPH_LINES[glyph][14 - 3*r -: 3];
        for (int c = 0; c < 3; c++) begin
          px = x + c;
          py = top + r;
          if (line[2 - c] && px >= 1 && px <= COLS && py >= 1 && py <= ROWS) begin
            if (mirror_on) begin
              px = COLS + 1 - px;
              py = ROWS + 1 - py;
            end
            pix.col = px[6:0];
            pix.row = py[6:0];
            pix.colour = req.colour;
            pix.last = 1'b0;
            drawn.push_back(pix);
          end
        end
      end
    end
    if (drawn.size() > 0) drawn[drawn.size()-1].last = 1'b1;
    foreach (drawn[i]) pixels_due.push_back(drawn[i]);
    cursor_col = cursor_col + ((req.code == fnt_pkg::CHAR_SPACE) ?
                               fnt_pkg::STEP_SPACE : fnt_pkg::STEP_GLYPH);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) draw_char(char_on_bus);
      if (!in_tvalid || in_tready) begin
        if (chars_to_send.size() > 0 && !take_gap()) begin
          char_on_bus = chars_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {char_on_bus.colour, char_on_bus.top_row, char_on_bus.start_col,
                       char_on_bus.code};
          in_tuser <= char_on_bus.first;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t want;
    out_tready <= !take_gap();
    if (rst_n && out_tvalid && out_tready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: pixel with none expected: col %0d row %0d colour %h last %b", $time,
                 out_tdata[6:0], out_tdata[13:7], out_tdata[37:14], out_tlast);
        failed <= 1'b1;
      end else begin
        want = pixels_due.pop_front();
        if (out_tdata[6:0] !== want.col || out_tdata[13:7] !== want.row ||
            out_tdata[37:14] !== want.colour || out_tlast !== want.last) begin
          $display({"%0t: expected col %0d row %0d colour %h last %b,",
                    " got col %0d row %0d colour %h last %b"},
                   $time, want.col, want.row, want.colour, want.last, out_tdata[6:0],
                   out_tdata[13:7], out_tdata[37:14], out_tlast);
          failed <= 1'b1;
        end
      end
    end
  end

  task automatic add_char(input logic [7:0] code, input logic first, input int start_col,
                          input int top_row, input logic [23:0] colour);
    char_req_t req;
    req.code = code;
    req.first = first;
    req.start_col = 8'(start_col);
    req.top_row = 8'(top_row);
    req.colour = colour;
    chars_to_send.push_back(req);
  endtask

  // mostly whole strings of drawable text, with some raw noise mixed in
  task automatic add_random_text(input int count);
    int          added;
    int          len;
    int          top;
    int          start;
    int          pick;
    logic [7:0]  code;
    logic [23:0] colour;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 int'($urandom_range(0, 191)) - 64, int'($urandom_range(0, 191)) - 64,
                 24'($urandom()));
        added++;
      end else begin
        len = int'($urandom_range(1, 8));
        start = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 191)) - 64 :
                                              int'($urandom_range(0, 32)) - 2;
        top = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 191)) - 64 :
                                            int'($urandom_range(0, 19)) - 3;
        colour = 24'($urandom());
        for (int i = 0; i < len; i++) begin
          pick = int'($urandom_range(0, 99));
          if (pick < 45) code = fnt_pkg::CHAR_A + 8'($urandom_range(0, 25));
          else if (pick < 70) code = fnt_pkg::CHAR_0 + 8'($urandom_range(0, 9));
          else if (pick < 85) code = fnt_pkg::CHAR_SPACE;
          else code = 8'($urandom_range(0, 255));
          add_char(code, i == 0, start, top, colour);
          added++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (chars_to_send.size() > 0 || in_tvalid) @(posedge clk);
    while (pixels_due.size() > 0) @(posedge clk);
    // characters with nothing to draw may still be in flight
    repeat (10) @(posedge clk);
  endtask

  task automatic write_invert(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    mirror_on = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_invert(1'b0);

    add_char("A", 1'b1, 1, 1, 24'h000000);
    add_char("Z", 1'b0, 0, 1, 24'hFFFFFF);
    add_char("0", 1'b0, 0, 1, 24'h123456);
    add_char("9", 1'b0, 0, 1, 24'hA5A5A5);
    add_char("8", 1'b0, 0, 1, 24'h5A5A5A);
    add_char(fnt_pkg::CHAR_SPACE, 1'b0, 0, 1, 24'h0000FF);
    add_char("a", 1'b0, 0, 1, 24'h00FF00);
    add_char(8'hFF, 1'b0, 0, 1, 24'hFF0000);
    add_char(8'h00, 1'b0, 0, 1, 24'h000001);
    add_char("@", 1'b1, 1, 7, 24'h800000);
    add_char("[", 1'b0, 0, 7, 24'h800000);
    add_char("/", 1'b0, 0, 7, 24'h800000);
    add_char(":", 1'b0, 0, 7, 24'h800000);
    add_char("8", 1'b0, 0, 7, 24'hC0FFEE);
    // partly off the left and top edges
    add_char("M", 1'b1, -1, -2, 24'h0F0F0F);
    // partly off the right and bottom edges
    add_char("W", 1'b1, 31, 14, 24'hF0F0F0);
    // cursor wraps from 127 to negative
    add_char("8", 1'b1, 127, 1, 24'h111111);
    add_char("H", 1'b0, 0, 1, 24'h222222);
    add_char("B", 1'b1, -64, 127, 24'h333333);
    add_char("E", 1'b1, 30, 12, 24'h444444);
    add_char("Q", 1'b0, 0, -64, 24'h555555);
    add_char("X", 1'b1, 10, 16, 24'h666666);
    add_char("8", 1'b1, 30, 12, 24'h777777);
    wait_idle();

    write_invert(1'b1);
    add_char("8", 1'b1, 1, 1, 24'h89ABCD);
    add_char("R", 1'b0, 0, 12, 24'hFEDCBA);
    add_random_text(100);
    wait_idle();

    write_invert(1'b0);
    add_random_text(100);
    wait_idle();

    // a stretch with no gaps on either side
    no_gaps = 1'b1;
    write_invert(1'b1);
    add_random_text(70);
    wait_idle();
    no_gaps = 1'b0;

    write_invert(1'b0);
    add_random_text(100);
    wait_idle();

    if (!failed) begin
      $display("[font3x5_text_pixel_generator] OK");
    end else begin
      $display("[font3x5_text_pixel_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[font3x5_text_pixel_generator] ERROR");
    $finish;
  end

endmodule
